// ===== src/rgbhsv_pkg.sv =====
// Package for the RGB to HSV pixel unit: stage payload types and constants.
// No dependencies.
package rgbhsv_pkg;

    localparam int PixW     = 8;
    localparam int NumW     = 2 * PixW;
    localparam int DivSteps = PixW;

    localparam logic [PixW-1:0] HueStep      = 8'd43;
    localparam logic [PixW-1:0] HueBaseRed   = 8'd0;
    localparam logic [PixW-1:0] HueBaseGreen = 8'd85;
    localparam logic [PixW-1:0] HueBaseBlue  = 8'd171;
    localparam logic [PixW-1:0] SatScale     = 8'd255;

    // after max/min and hue sector select
    typedef struct packed {
        logic [PixW-1:0] hi;
        logic [PixW-1:0] chroma;
        logic [PixW-1:0] absdiff;
        logic [PixW-1:0] base;
        logic            neg;
    } rgbhsv_front_t;

    // division pipeline payload
    typedef struct packed {
        logic [PixW-1:0] hi;
        logic [PixW-1:0] chroma;
        logic [PixW-1:0] base;
        logic            neg;
        logic [NumW-1:0] sat_rem;
        logic [NumW-1:0] hue_rem;
        logic [PixW-1:0] sat_q;
        logic [PixW-1:0] hue_q;
    } rgbhsv_div_t;

endpackage

// ===== src/rgb_to_hsv_pixel_unit.sv =====
// Throughput: one pixel per clock while m_ready is high; a low m_ready stalls the full stages.
// Stages: max/min select, numerator multiply, eight restoring division steps (one quotient
// bit per stage, saturation and hue dividers side by side), final hue wrap.
// Every stage holds when the next one is full and stalled, so bubbles are squeezed out.
// Reset: aresetn synchronous, active low; clears all stage valid bits only.
// Depends on rgbhsv_pkg.
module rgb_to_hsv_pixel_unit
    import rgbhsv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_blue,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_red,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_hue,
    output logic [7:0]  m_saturation,
    output logic [7:0]  m_brightness
);

    // ---------------- stage enables (per-stage ready chain) ----------------
    logic                front_valid_reg;
    rgbhsv_front_t       front_reg, front_next;
    logic                div_valid_reg [0:DivSteps];
    rgbhsv_div_t         div_reg       [0:DivSteps];
    rgbhsv_div_t         div_next      [0:DivSteps];
    logic                div_en        [0:DivSteps];
    logic                out_valid_reg;
    logic [PixW-1:0]     hue_reg, hue_next;
    logic [PixW-1:0]     sat_reg, sat_next;
    logic [PixW-1:0]     bright_reg;
    logic                out_en;
    logic                front_en;

    // A stage may load when it is empty or its contents move on this cycle.
    assign out_en = !out_valid_reg || m_ready;

    always_comb begin
        div_en[DivSteps] = !div_valid_reg[DivSteps] || out_en;
        for (int i = DivSteps - 1; i >= 0; i--) begin
            div_en[i] = !div_valid_reg[i] || div_en[i+1];
        end
    end

    assign front_en = !front_valid_reg || div_en[0];
    assign s_ready  = front_en;

    // ---------------- front stage: max, min, hue sector ----------------
    logic [PixW-1:0] hi, lo, mx_rg, mn_rg, sel_p, sel_q;
    logic [PixW:0]   diff;

    always_comb begin
        mx_rg = (s_red > s_green) ? s_red : s_green;
        hi    = (mx_rg > s_blue) ? mx_rg : s_blue;
        mn_rg = (s_red < s_green) ? s_red : s_green;
        lo    = (mn_rg < s_blue) ? mn_rg : s_blue;

        // red wins ties, then green, then blue
        if (hi == s_red) begin
            sel_p           = s_green;
            sel_q           = s_blue;
            front_next.base = HueBaseRed;
        end else if (hi == s_green) begin
            sel_p           = s_blue;
            sel_q           = s_red;
            front_next.base = HueBaseGreen;
        end else begin
            sel_p           = s_red;
            sel_q           = s_green;
            front_next.base = HueBaseBlue;
        end

        diff               = {1'b0, sel_p} - {1'b0, sel_q};
        front_next.neg     = diff[PixW];
        front_next.absdiff = diff[PixW] ? PixW'(-diff) : diff[PixW-1:0];
        front_next.hi      = hi;
        front_next.chroma  = hi - lo;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else if (front_en) begin
            front_valid_reg <= s_valid;
        end
        if (front_en) begin
            front_reg <= front_next;
        end
    end

    // ---------------- numerator stage ----------------
    always_comb begin
        div_next[0].hi      = front_reg.hi;
        div_next[0].chroma  = front_reg.chroma;
        div_next[0].base    = front_reg.base;
        div_next[0].neg     = front_reg.neg;
        div_next[0].sat_rem = NumW'(front_reg.chroma) * NumW'(SatScale);
        div_next[0].hue_rem = NumW'(front_reg.absdiff) * NumW'(HueStep);
        div_next[0].sat_q   = '0;
        div_next[0].hue_q   = '0;
    end

    // ---------------- restoring division, one quotient bit per stage ----------------
    // Both quotients fit in 8 bits (chroma <= max, |diff| <= chroma), so the
    // divisor shifted by the bit weight is compared against the running remainder.
    for (genvar i = 0; i < DivSteps; i++) begin : g_div
        localparam int K = DivSteps - 1 - i;
        logic [NumW-1:0] sat_d, hue_d;
        logic            sat_take, hue_take;

        always_comb begin
            sat_d    = NumW'(div_reg[i].hi) << K;
            hue_d    = NumW'(div_reg[i].chroma) << K;
            sat_take = div_reg[i].sat_rem >= sat_d;
            hue_take = div_reg[i].hue_rem >= hue_d;

            div_next[i+1]          = div_reg[i];
            div_next[i+1].sat_rem  = sat_take ? div_reg[i].sat_rem - sat_d
                                              : div_reg[i].sat_rem;
            div_next[i+1].hue_rem  = hue_take ? div_reg[i].hue_rem - hue_d
                                              : div_reg[i].hue_rem;
            div_next[i+1].sat_q[K] = sat_take;
            div_next[i+1].hue_q[K] = hue_take;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= DivSteps; i++) begin
                div_valid_reg[i] <= 1'b0;
            end
        end else begin
            if (div_en[0]) begin
                div_valid_reg[0] <= front_valid_reg;
            end
            for (int i = 1; i <= DivSteps; i++) begin
                if (div_en[i]) begin
                    div_valid_reg[i] <= div_valid_reg[i-1];
                end
            end
        end
        for (int i = 0; i <= DivSteps; i++) begin
            if (div_en[i]) begin
                div_reg[i] <= div_next[i];
            end
        end
    end

    // ---------------- output stage ----------------
    // Zero chroma covers both black and grey pixels: saturation and hue are 0.
    // Otherwise saturation is never 0, since 255*chroma >= max.
    logic [PixW-1:0] hue_part;

    always_comb begin
        hue_part = div_reg[DivSteps].neg ? PixW'(-div_reg[DivSteps].hue_q)
                                         : div_reg[DivSteps].hue_q;
        if (div_reg[DivSteps].chroma == '0) begin
            hue_next = '0;
            sat_next = '0;
        end else begin
            hue_next = div_reg[DivSteps].base + hue_part;
            sat_next = div_reg[DivSteps].sat_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_en) begin
            out_valid_reg <= div_valid_reg[DivSteps];
        end
        if (out_en) begin
            hue_reg    <= hue_next;
            sat_reg    <= sat_next;
            bright_reg <= div_reg[DivSteps].hi;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_hue        = hue_reg;
    assign m_saturation = sat_reg;
    assign m_brightness = bright_reg;

endmodule
